>>> rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers for the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_SCALE      = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_WHEELBASE = 4'd1;

    localparam logic [15:0] SPEED_SCALE_RESET       = 16'd19149;
    localparam logic [15:0] INVERSE_WHEELBASE_RESET = 16'd1164;

    // shared multiplier operand and product widths
    localparam int MUL_A_WIDTH = 34;
    localparam int MUL_B_WIDTH = 32;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

    // round(2^32 / (2 pi)), converts rad to binary angle
    localparam logic signed [MUL_B_WIDTH-1:0] INV_TWO_PI_Q32 = 32'sd683565276;

    // cordic
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_WIDTH     = 34;
    localparam int CORDIC_STEP_BITS = 4;
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN_Q30  = 34'sd652032874;
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_QUARTER   = 34'sd1073741824;
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_HALF_TURN = 34'sd2147483648;

    localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic signed [MUL_A_WIDTH-1:0] a;
        logic signed [MUL_B_WIDTH-1:0] b;
    } mul_op_t;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_RUN,
        CP_FIX
    } cordic_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V,
        ST_Q,
        ST_W,
        ST_VDT,
        ST_WDT,
        ST_DH,
        ST_DHGET,
        ST_CWAIT,
        ST_DX,
        ST_DY,
        ST_PY,
        ST_OUT
    } state_t;

    // round half up, shift right and saturate to signed 16 bits
    function automatic logic signed [15:0] round_sat16(
        input logic signed [PROD_WIDTH-1:0] p,
        input int                           sh
    );
        logic signed [PROD_WIDTH-1:0] t;
        t = (p + (66'sd1 <<< (sh - 1))) >>> sh;
        if (t > 66'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -66'sd32768) begin
            return 16'sh8000;
        end else begin
            return t[15:0];
        end
    endfunction

endpackage

>>> rtl/core/differential_drive_odometry_top.sv
// A new input word is taken only once the previous result word has been issued:
// the 16 cordic iterations on the old heading plus the multiply steps that follow
// them must finish first, and s_tready is high only while the core is idle.
// Velocity and heading products share one registered 34x32 multiplier meanwhile.
// Reset (aresetn low, synchronous) clears pose and heading to zero, restores the
// default gains and empties the output register.
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Fixed point dead-reckoning odometry for a two-wheel differential drive.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top #(
    parameter int POSITION_WIDTH = 32,
    parameter int ANGLE_WIDTH    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddo_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [15:0]                         cfg_data,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_speed [15:0], right_speed [31:16], elapsed_time [47:32]
    input  logic [47:0]                         s_tdata,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pos_x [31:0], pos_y [63:32], heading [79:64],
    // linear_velocity [95:80], angular_velocity [111:96]
    output logic [111:0]                        m_tdata
);

    localparam int PW = POSITION_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int AB = ddo_pkg::MUL_A_WIDTH;
    localparam int BB = ddo_pkg::MUL_B_WIDTH;
    localparam int PB = ddo_pkg::PROD_WIDTH;
    localparam int EW = (PW > 32) ? PW : 32;

    localparam logic signed [PW+1:0] POSE_MAX = {3'b000, {(PW-1){1'b1}}};
    localparam logic signed [PW+1:0] POSE_MIN = {3'b111, {(PW-1){1'b0}}};
    localparam logic signed [EW-1:0] OUT_MAX  = EW'($signed(32'h7FFF_FFFF));
    localparam logic signed [EW-1:0] OUT_MIN  = EW'($signed(32'h8000_0000));

    ddo_pkg::state_t state_reg, state_next;

    logic [15:0]          speed_scale_reg, inverse_wheelbase_reg;
    logic signed [15:0]   left_reg, right_reg;
    logic [15:0]          dt_reg;
    logic signed [15:0]   v_reg, w_reg;
    logic signed [31:0]   vdt_reg;
    logic [AW-1:0]        dh_reg;
    logic signed [PW-1:0] pose_x_reg, pose_y_reg;
    logic [AW-1:0]        heading_reg;

    logic                 m_tvalid_reg;
    logic signed [31:0]   out_x_reg, out_y_reg;
    logic [15:0]          out_heading_reg;
    logic signed [15:0]   out_v_reg, out_w_reg;

    ddo_pkg::mul_op_t     mul_op;
    logic signed [PB-1:0] prod;

    logic                 cordic_start, cordic_done;
    logic signed [31:0]   cordic_cos, cordic_sin;

    logic                 in_take, out_free;
    logic signed [16:0]   lr_sum, lr_diff;
    logic signed [PB-1:0] pos_round, heading_round;
    logic signed [PW+1:0] pose_delta, pose_sum;
    logic signed [PW-1:0] pose_sel, pose_sat;
    logic signed [EW-1:0] pose_x_ext, pose_y_ext;
    logic signed [31:0]   pos_x_clip, pos_y_clip;
    logic [15:0]          heading16;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ddo_pkg::ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cordic_start = in_take;

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   ({s_tready ? heading_reg : heading_reg, {(32-AW){1'b0}}}),
        .done    (cordic_done),
        .cos_out (cordic_cos),
        .sin_out (cordic_sin)
    );

    ddo_mul u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .prod (prod)
    );

    assign lr_sum  = 17'(left_reg) + 17'(right_reg);
    assign lr_diff = 17'(right_reg) - 17'(left_reg);

    // position step: round and shift out the Q2.30 and Q24.8 fractions
    assign pos_round  = (prod + (66'sd1 <<< 37)) >>> 38;
    assign pose_delta = pos_round[PW+1:0];
    assign pose_sel   = (state_reg == ddo_pkg::ST_DY) ? pose_x_reg : pose_y_reg;
    assign pose_sum   = (PW+2)'(pose_sel) + pose_delta;

    always_comb begin
        if (pose_sum > POSE_MAX) begin
            pose_sat = POSE_MAX[PW-1:0];
        end else if (pose_sum < POSE_MIN) begin
            pose_sat = POSE_MIN[PW-1:0];
        end else begin
            pose_sat = pose_sum[PW-1:0];
        end
    end

    // heading step only needs its low AW bits after the shift
    assign heading_round = prod + (66'sd1 <<< (55 - AW));

    assign pose_x_ext = EW'(pose_x_reg);
    assign pose_y_ext = EW'(pose_y_reg);

    always_comb begin
        if (pose_x_ext > OUT_MAX) begin
            pos_x_clip = OUT_MAX[31:0];
        end else if (pose_x_ext < OUT_MIN) begin
            pos_x_clip = OUT_MIN[31:0];
        end else begin
            pos_x_clip = pose_x_ext[31:0];
        end
        if (pose_y_ext > OUT_MAX) begin
            pos_y_clip = OUT_MAX[31:0];
        end else if (pose_y_ext < OUT_MIN) begin
            pos_y_clip = OUT_MIN[31:0];
        end else begin
            pos_y_clip = pose_y_ext[31:0];
        end
    end

    generate
        if (AW >= 16) begin : g_heading_top
            assign heading16 = heading_reg[AW-1 -: 16];
        end else begin : g_heading_pad
            assign heading16 = {heading_reg, {(16-AW){1'b0}}};
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        mul_op.a   = AB'(lr_sum);
        mul_op.b   = BB'(speed_scale_reg);
        unique case (state_reg)
            ddo_pkg::ST_IDLE: begin
                if (in_take) begin
                    state_next = ddo_pkg::ST_V;
                end
            end
            ddo_pkg::ST_V: begin
                mul_op.a   = AB'(lr_sum);
                mul_op.b   = BB'(speed_scale_reg);
                state_next = ddo_pkg::ST_Q;
            end
            ddo_pkg::ST_Q: begin
                mul_op.a   = AB'(lr_diff);
                mul_op.b   = BB'(speed_scale_reg);
                state_next = ddo_pkg::ST_W;
            end
            ddo_pkg::ST_W: begin
                // (r - l) * gain is in the product register now
                mul_op.a   = prod[AB-1:0];
                mul_op.b   = BB'(inverse_wheelbase_reg);
                state_next = ddo_pkg::ST_VDT;
            end
            ddo_pkg::ST_VDT: begin
                mul_op.a   = AB'(v_reg);
                mul_op.b   = BB'(dt_reg);
                state_next = ddo_pkg::ST_WDT;
            end
            ddo_pkg::ST_WDT: begin
                mul_op.a   = AB'(w_reg);
                mul_op.b   = BB'(dt_reg);
                state_next = ddo_pkg::ST_DH;
            end
            ddo_pkg::ST_DH: begin
                mul_op.a   = AB'($signed(prod[31:0]));
                mul_op.b   = ddo_pkg::INV_TWO_PI_Q32;
                state_next = ddo_pkg::ST_DHGET;
            end
            ddo_pkg::ST_DHGET: begin
                state_next = ddo_pkg::ST_CWAIT;
            end
            ddo_pkg::ST_CWAIT: begin
                if (cordic_done) begin
                    state_next = ddo_pkg::ST_DX;
                end
            end
            ddo_pkg::ST_DX: begin
                mul_op.a   = AB'(vdt_reg);
                mul_op.b   = cordic_cos;
                state_next = ddo_pkg::ST_DY;
            end
            ddo_pkg::ST_DY: begin
                mul_op.a   = AB'(vdt_reg);
                mul_op.b   = cordic_sin;
                state_next = ddo_pkg::ST_PY;
            end
            ddo_pkg::ST_PY: begin
                state_next = ddo_pkg::ST_OUT;
            end
            ddo_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ddo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ddo_pkg::ST_IDLE;
            speed_scale_reg       <= ddo_pkg::SPEED_SCALE_RESET;
            inverse_wheelbase_reg <= ddo_pkg::INVERSE_WHEELBASE_RESET;
            pose_x_reg            <= '0;
            pose_y_reg            <= '0;
            heading_reg           <= '0;
            m_tvalid_reg          <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ddo_pkg::REG_SPEED_SCALE) begin
                    speed_scale_reg <= cfg_data;
                end else if (cfg_index == ddo_pkg::REG_INVERSE_WHEELBASE) begin
                    inverse_wheelbase_reg <= cfg_data;
                end
            end
            if (state_reg == ddo_pkg::ST_DY) begin
                pose_x_reg <= pose_sat;
            end
            if (state_reg == ddo_pkg::ST_PY) begin
                pose_y_reg  <= pose_sat;
                heading_reg <= heading_reg + dh_reg;
            end
            if (state_reg == ddo_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            left_reg  <= $signed(s_tdata[15:0]);
            right_reg <= $signed(s_tdata[31:16]);
            dt_reg    <= s_tdata[47:32];
        end
        if (state_reg == ddo_pkg::ST_Q) begin
            v_reg <= ddo_pkg::round_sat16(prod, 13);
        end
        if (state_reg == ddo_pkg::ST_VDT) begin
            w_reg <= ddo_pkg::round_sat16(prod, 20);
        end
        if (state_reg == ddo_pkg::ST_WDT) begin
            vdt_reg <= prod[31:0];
        end
        if (state_reg == ddo_pkg::ST_DHGET) begin
            dh_reg <= heading_round[55 -: AW];
        end
        if (state_reg == ddo_pkg::ST_OUT && out_free) begin
            out_x_reg       <= pos_x_clip;
            out_y_reg       <= pos_y_clip;
            out_heading_reg <= heading16;
            out_v_reg       <= v_reg;
            out_w_reg       <= w_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_w_reg, out_v_reg, out_heading_reg, out_y_reg, out_x_reg};

`ifndef SYNTHESIS
    a_cordic_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddo_pkg::ST_DX) |-> cordic_done)
        else $error("position step issued before cordic finished");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !cordic_done))
        else $error("input taken while an update is still running");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ddo_pkg::ST_OUT))
        else $error("result word raised outside the output step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && state_reg == ddo_pkg::ST_OUT) |=>
            (state_reg == ddo_pkg::ST_OUT))
        else $error("pending result word would be overwritten");
`endif

endmodule

>>> rtl/core/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                                     aclk,
    input  ddo_pkg::mul_op_t                         op,
    output logic signed [ddo_pkg::PROD_WIDTH-1:0]    prod
);

    logic signed [ddo_pkg::PROD_WIDTH-1:0] prod_reg;
    logic signed [ddo_pkg::PROD_WIDTH-1:0] prod_next;

    assign prod_next = $signed(op.a) * $signed(op.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, Q2.30 cos/sin.
// ----------------------------------------------------------------------------
module ddo_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int CW = ddo_pkg::CORDIC_WIDTH;

    ddo_pkg::cordic_phase_t phase_reg, phase_next;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic [ddo_pkg::CORDIC_STEP_BITS-1:0] step_reg;
    logic                 flip_reg, flip_next;
    logic                 done_reg;
    logic signed [31:0]   cos_reg, sin_reg;

    logic signed [CW-1:0] z_start, xs, ys, atan_s;

    assign z_start = CW'($signed(angle));
    assign xs      = x_reg >>> step_reg;
    assign ys      = y_reg >>> step_reg;
    assign atan_s  = $signed(CW'(ddo_pkg::ATAN_TABLE[step_reg]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ddo_pkg::CP_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            if (start) begin
                done_reg <= 1'b0;
                step_reg <= '0;
            end else if (phase_reg == ddo_pkg::CP_RUN) begin
                step_reg <= step_reg + 1'b1;
            end else if (phase_reg == ddo_pkg::CP_FIX) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        if (phase_reg == ddo_pkg::CP_FIX) begin
            cos_reg <= flip_reg ? 32'(-x_reg) : 32'(x_reg);
            sin_reg <= flip_reg ? 32'(-y_reg) : 32'(y_reg);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        if (start) begin
            phase_next = ddo_pkg::CP_RUN;
            x_next     = ddo_pkg::CORDIC_GAIN_Q30;
            y_next     = '0;
            // fold the far half-plane onto the near one, negate at the end
            if (z_start > ddo_pkg::CORDIC_QUARTER) begin
                z_next    = z_start - ddo_pkg::CORDIC_HALF_TURN;
                flip_next = 1'b1;
            end else if (z_start < -ddo_pkg::CORDIC_QUARTER) begin
                z_next    = z_start + ddo_pkg::CORDIC_HALF_TURN;
                flip_next = 1'b1;
            end else begin
                z_next    = z_start;
                flip_next = 1'b0;
            end
        end else begin
            unique case (phase_reg)
                ddo_pkg::CP_IDLE: begin
                    phase_next = ddo_pkg::CP_IDLE;
                end
                ddo_pkg::CP_RUN: begin
                    if (!z_reg[CW-1]) begin
                        x_next = x_reg - ys;
                        y_next = y_reg + xs;
                        z_next = z_reg - atan_s;
                    end else begin
                        x_next = x_reg + ys;
                        y_next = y_reg - xs;
                        z_next = z_reg + atan_s;
                    end
                    if (step_reg == ddo_pkg::CORDIC_STEP_BITS'(ddo_pkg::CORDIC_STEPS - 1)) begin
                        phase_next = ddo_pkg::CP_FIX;
                    end
                end
                ddo_pkg::CP_FIX: begin
                    phase_next = ddo_pkg::CP_IDLE;
                end
                default: begin
                    phase_next = ddo_pkg::CP_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule
